[src/sapc_pkg.sv]
// ----------------------------------------------------------------------------
// sapc_pkg
// Types and constants of the sos alert protocol controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sapc_pkg;

  // widths of the fixed fields
  localparam int TIME_W    = 32;
  localparam int ID_W      = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_SLOTS = 3;
  localparam int NUM_CAND  = 5;

  // alarm mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_OUT  = 3'b010,
    MODE_IN   = 3'b100
  } mode_t;

  // alarm_state codes on the result channel
  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_OUT  = 2'd1;
  localparam logic [1:0] STATE_IN   = 2'd2;

  // result actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_TONE = 2'd2;

  // packet types
  localparam logic [1:0] PKT_ALARM = 2'd0;
  localparam logic [1:0] PKT_CLEAR = 2'd1;
  localparam logic [1:0] PKT_ACK   = 2'd2;
  localparam logic [1:0] PKT_OTHER = 2'd3;

  // input operations
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUB_ID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARTNER_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_MS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SILENT_MS  = 3'd6;

  // fixed protocol intervals
  localparam logic [TIME_W-1:0] CLEAR_GAP_MS = 32'd300;
  localparam logic [TIME_W-1:0] ACK_GAP_MS   = 32'd2000;
  localparam logic [TIME_W-1:0] TONE_GAP_MS  = 32'd5000;

  // one queued action
  typedef struct packed {
    logic [1:0]      action;
    logic [1:0]      tx_type;
    logic [ID_W-1:0] tx_dest;
    logic            tx_active;
  } act_t;

  localparam act_t ACT_IDLE_ENTRY = '{action: ACT_NONE, tx_type: PKT_ALARM,
                                      tx_dest: '0, tx_active: 1'b0};
  localparam act_t ACT_TONE_ENTRY = '{action: ACT_TONE, tx_type: PKT_ALARM,
                                      tx_dest: '0, tx_active: 1'b0};

endpackage

`default_nettype wire

[src/sos_alert_protocol_controller.sv]
// ----------------------------------------------------------------------------
// sos_alert_protocol_controller
// Alarm controller: button press detection, alarm raise and cancel, periodic
// resend, clear bursts, incoming alarm ack, tone and silence timeout.
// ----------------------------------------------------------------------------
// Pipeline: an item passes through the input register and then the result buffer.
// Throughput: an item yields one to four results, one result per cycle while
//   out_ready is high; the next item is taken into the input register while
//   results of the previous one drain.
// Reset: synchronous rst_n puts the block in idle with all timers at zero and
//   the configuration registers at their default values.
`default_nettype none

module sos_alert_protocol_controller #(
  parameter int CLEAR_BURST = 3,
  parameter int ID_BITS     = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [sapc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sapc_pkg::CFG_W-1:0]        cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_operation,
  input  wire logic [31:0]                       in_now_ms,
  input  wire logic                              in_button_down,
  input  wire logic [1:0]                        in_rx_type,
  input  wire logic [7:0]                        in_rx_source,
  input  wire logic [7:0]                        in_rx_dest,
  input  wire logic                              in_rx_active,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_action,
  output logic [1:0]                             out_tx_type,
  output logic [7:0]                             out_tx_dest,
  output logic                                   out_tx_active,
  output logic [1:0]                             out_alarm_state,
  output logic [7:0]                             out_peer,
  output logic                                   out_delivered,
  output logic                                   out_last
);

  localparam int CLR_W = $clog2(CLEAR_BURST + 1);
  localparam logic [CLR_W-1:0] CLEAR_INIT = CLR_W'(CLEAR_BURST);
  localparam logic [7:0] ID_MASK = (ID_BITS >= 8) ? 8'hFF : 8'((1 << ID_BITS) - 1);
  localparam int TW = sapc_pkg::TIME_W;

  // configuration registers
  logic [7:0]  own_id_r, hub_id_r, partner_id_r, bcast_id_r;
  logic [15:0] long_ms_r, resend_ms_r, silent_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= 8'd1;
      hub_id_r     <= 8'd0;
      partner_id_r <= 8'd2;
      bcast_id_r   <= 8'd255;
      long_ms_r    <= 16'd2000;
      resend_ms_r  <= 16'd1000;
      silent_ms_r  <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sapc_pkg::REG_OWN_ID:     own_id_r     <= cfg_wdata[7:0];
        sapc_pkg::REG_HUB_ID:     hub_id_r     <= cfg_wdata[7:0];
        sapc_pkg::REG_PARTNER_ID: partner_id_r <= cfg_wdata[7:0];
        sapc_pkg::REG_BCAST_ID:   bcast_id_r   <= cfg_wdata[7:0];
        sapc_pkg::REG_LONG_MS:    long_ms_r    <= cfg_wdata;
        sapc_pkg::REG_RESEND_MS:  resend_ms_r  <= cfg_wdata;
        sapc_pkg::REG_SILENT_MS:  silent_ms_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic          ip_vld_r;
  logic          ip_op_r;
  logic [TW-1:0] ip_now_r;
  logic          ip_btn_r;
  logic [1:0]    ip_type_r;
  logic [7:0]    ip_src_r;
  logic [7:0]    ip_dst_r;
  logic          ip_act_r;

  // result buffer
  logic [2:0]           cnt_r;
  sapc_pkg::act_t       slot_r [sapc_pkg::NUM_SLOTS];
  logic [1:0]           st_state_r;
  logic [7:0]           st_peer_r;
  logic                 st_deliv_r;

  logic buf_free, adv;

  assign buf_free = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign adv      = ip_vld_r && buf_free;
  assign in_ready = !ip_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_vld_r <= 1'b0;
    end else if (in_ready) begin
      ip_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ip_op_r   <= in_operation;
      ip_now_r  <= in_now_ms;
      ip_btn_r  <= in_button_down;
      ip_type_r <= in_rx_type;
      ip_src_r  <= in_rx_source;
      ip_dst_r  <= in_rx_dest;
      ip_act_r  <= in_rx_active;
    end
  end

  // protocol state
  sapc_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]      peer_r, peer_nxt;
  logic            deliv_r, deliv_nxt;
  logic [TW-1:0]   last_send_r, last_send_nxt;
  logic [TW-1:0]   last_rx_r, last_rx_nxt;
  logic [TW-1:0]   last_ack_r, last_ack_nxt;
  logic [TW-1:0]   last_tone_r, last_tone_nxt;
  logic [TW-1:0]   last_clear_r, last_clear_nxt;
  logic [TW-1:0]   press_start_r, press_start_nxt;
  logic [CLR_W-1:0] clears_r, clears_nxt;
  logic            btn_was_r, btn_was_nxt;
  logic            long_done_r, long_done_nxt;

  // candidate actions in emission order
  sapc_pkg::act_t cand [sapc_pkg::NUM_CAND];
  logic [sapc_pkg::NUM_CAND-1:0] cand_v;

  logic [7:0]    src_m, dst_m, hub_m, own_m, partner_m;
  logic          pressed, rising, long_fire;
  logic [TW-1:0] hold_ms, send_gap, clear_gap, rx_gap, ack_gap, tone_gap;

  assign src_m     = ip_src_r & ID_MASK;
  assign dst_m     = ip_dst_r & ID_MASK;
  assign hub_m     = hub_id_r & ID_MASK;
  assign own_m     = own_id_r & ID_MASK;
  assign partner_m = partner_id_r & ID_MASK;
  assign pressed   = ip_btn_r;
  assign rising    = pressed && !btn_was_r;

  // next state and actions of the item in the input register
  always_comb begin
    mode_nxt        = mode_r;
    peer_nxt        = peer_r;
    deliv_nxt       = deliv_r;
    last_send_nxt   = last_send_r;
    last_rx_nxt     = last_rx_r;
    last_ack_nxt    = last_ack_r;
    last_tone_nxt   = last_tone_r;
    last_clear_nxt  = last_clear_r;
    press_start_nxt = press_start_r;
    clears_nxt      = clears_r;
    btn_was_nxt     = btn_was_r;
    long_done_nxt   = long_done_r;
    cand_v          = '0;
    for (int i = 0; i < sapc_pkg::NUM_CAND; i++) begin
      cand[i] = sapc_pkg::ACT_IDLE_ENTRY;
    end
    hold_ms   = '0;
    long_fire = 1'b0;
    send_gap  = '0;
    clear_gap = '0;
    rx_gap    = '0;
    ack_gap   = '0;
    tone_gap  = '0;

    if (ip_op_r == sapc_pkg::OP_PACKET) begin
      // received packet, hub traffic dropped
      if (src_m != hub_m) begin
        unique case (ip_type_r)
          sapc_pkg::PKT_ALARM: begin
            if (ip_act_r) begin
              last_rx_nxt = ip_now_r;
              if (mode_r == sapc_pkg::MODE_IDLE) begin
                mode_nxt      = sapc_pkg::MODE_IN;
                peer_nxt      = src_m;
                deliv_nxt     = 1'b0;
                last_tone_nxt = ip_now_r;
                last_ack_nxt  = '0;
                cand_v[0]     = 1'b1;
                cand[0]       = sapc_pkg::ACT_TONE_ENTRY;
              end
            end else if (mode_r == sapc_pkg::MODE_IN && src_m == peer_r) begin
              mode_nxt  = sapc_pkg::MODE_IDLE;
              peer_nxt  = '0;
              deliv_nxt = 1'b0;
            end
          end
          sapc_pkg::PKT_CLEAR: begin
            if (mode_r == sapc_pkg::MODE_IN && src_m == peer_r) begin
              mode_nxt  = sapc_pkg::MODE_IDLE;
              peer_nxt  = '0;
              deliv_nxt = 1'b0;
            end
          end
          sapc_pkg::PKT_ACK: begin
            if (mode_r == sapc_pkg::MODE_OUT && dst_m == own_m) begin
              deliv_nxt = 1'b1;
            end
          end
          sapc_pkg::PKT_OTHER: ;
          default: ;
        endcase
      end
    end else begin
      // button edge tracking
      if (rising) begin
        press_start_nxt = ip_now_r;
        long_done_nxt   = 1'b0;
      end
      hold_ms   = ip_now_r - press_start_nxt;
      long_fire = pressed && !long_done_nxt && (hold_ms >= {16'd0, long_ms_r});

      // long press
      if (long_fire) begin
        long_done_nxt = 1'b1;
        unique case (mode_r)
          sapc_pkg::MODE_IDLE: begin
            mode_nxt      = sapc_pkg::MODE_OUT;
            peer_nxt      = partner_m;
            last_send_nxt = '0;
            cand_v[0]     = 1'b1;
            cand[0]       = sapc_pkg::ACT_TONE_ENTRY;
          end
          sapc_pkg::MODE_OUT: begin
            mode_nxt       = sapc_pkg::MODE_IDLE;
            peer_nxt       = '0;
            deliv_nxt      = 1'b0;
            clears_nxt     = CLEAR_INIT;
            last_clear_nxt = '0;
          end
          default: begin
            mode_nxt  = sapc_pkg::MODE_IDLE;
            peer_nxt  = '0;
            deliv_nxt = 1'b0;
          end
        endcase
      end

      // short press release dismisses an incoming alarm
      if (!pressed && btn_was_r && !long_done_nxt && mode_r == sapc_pkg::MODE_IN) begin
        mode_nxt  = sapc_pkg::MODE_IDLE;
        peer_nxt  = '0;
        deliv_nxt = 1'b0;
      end
      btn_was_nxt = pressed;

      // periodic resend of own alarm
      send_gap = ip_now_r - last_send_nxt;
      if (mode_nxt == sapc_pkg::MODE_OUT && send_gap >= {16'd0, resend_ms_r}) begin
        last_send_nxt = ip_now_r;
        cand_v[1]     = 1'b1;
        cand[1]       = '{action: sapc_pkg::ACT_SEND, tx_type: sapc_pkg::PKT_ALARM,
                          tx_dest: bcast_id_r, tx_active: 1'b1};
      end

      // clear burst
      clear_gap = ip_now_r - last_clear_nxt;
      if (clears_nxt != '0 && clear_gap >= sapc_pkg::CLEAR_GAP_MS) begin
        last_clear_nxt = ip_now_r;
        clears_nxt     = clears_nxt - CLR_W'(1);
        cand_v[2]      = 1'b1;
        cand[2]        = '{action: sapc_pkg::ACT_SEND, tx_type: sapc_pkg::PKT_CLEAR,
                           tx_dest: bcast_id_r, tx_active: 1'b0};
      end

      // incoming alarm: timeout, ack and tone
      rx_gap   = ip_now_r - last_rx_r;
      ack_gap  = ip_now_r - last_ack_r;
      tone_gap = ip_now_r - last_tone_r;
      if (mode_nxt == sapc_pkg::MODE_IN) begin
        if (rx_gap > {16'd0, silent_ms_r}) begin
          mode_nxt  = sapc_pkg::MODE_IDLE;
          peer_nxt  = '0;
          deliv_nxt = 1'b0;
        end else begin
          if (ack_gap >= sapc_pkg::ACK_GAP_MS) begin
            last_ack_nxt = ip_now_r;
            cand_v[3]    = 1'b1;
            cand[3]      = '{action: sapc_pkg::ACT_SEND, tx_type: sapc_pkg::PKT_ACK,
                             tx_dest: peer_nxt, tx_active: 1'b0};
          end
          if (tone_gap >= sapc_pkg::TONE_GAP_MS) begin
            last_tone_nxt = ip_now_r;
            cand_v[4]     = 1'b1;
            cand[4]       = sapc_pkg::ACT_TONE_ENTRY;
          end
        end
      end
    end
  end

  // pack the candidate actions into the buffer slots
  sapc_pkg::act_t slot_nxt [sapc_pkg::NUM_SLOTS];
  logic [2:0]     n_act;

  always_comb begin
    n_act = '0;
    for (int i = 0; i < sapc_pkg::NUM_SLOTS; i++) begin
      slot_nxt[i] = sapc_pkg::ACT_IDLE_ENTRY;
    end
    for (int i = 0; i < sapc_pkg::NUM_CAND; i++) begin
      if (cand_v[i] && n_act < 3'(sapc_pkg::NUM_SLOTS)) begin
        slot_nxt[n_act[1:0]] = cand[i];
        n_act = n_act + 3'd1;
      end
    end
  end

  // status code of the mode after the item
  logic [1:0] state_code;

  always_comb begin
    unique case (mode_nxt)
      sapc_pkg::MODE_IDLE: state_code = sapc_pkg::STATE_IDLE;
      sapc_pkg::MODE_OUT:  state_code = sapc_pkg::STATE_OUT;
      sapc_pkg::MODE_IN:   state_code = sapc_pkg::STATE_IN;
      default:             state_code = sapc_pkg::STATE_IDLE;
    endcase
  end

  // state update when the item moves into the result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= sapc_pkg::MODE_IDLE;
      peer_r        <= '0;
      deliv_r       <= 1'b0;
      last_send_r   <= '0;
      last_rx_r     <= '0;
      last_ack_r    <= '0;
      last_tone_r   <= '0;
      last_clear_r  <= '0;
      press_start_r <= '0;
      clears_r      <= '0;
      btn_was_r     <= 1'b0;
      long_done_r   <= 1'b0;
    end else if (adv) begin
      mode_r        <= mode_nxt;
      peer_r        <= peer_nxt;
      deliv_r       <= deliv_nxt;
      last_send_r   <= last_send_nxt;
      last_rx_r     <= last_rx_nxt;
      last_ack_r    <= last_ack_nxt;
      last_tone_r   <= last_tone_nxt;
      last_clear_r  <= last_clear_nxt;
      press_start_r <= press_start_nxt;
      clears_r      <= clears_nxt;
      btn_was_r     <= btn_was_nxt;
      long_done_r   <= long_done_nxt;
    end
  end

  // result buffer count: queued actions plus the closing status item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= n_act + 3'd1;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // result buffer payload, shifted by one on each transfer
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < sapc_pkg::NUM_SLOTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
      st_state_r <= state_code;
      st_peer_r  <= peer_nxt;
      st_deliv_r <= deliv_nxt;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < sapc_pkg::NUM_SLOTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
      slot_r[sapc_pkg::NUM_SLOTS-1] <= sapc_pkg::ACT_IDLE_ENTRY;
    end
  end

  // result channel
  sapc_pkg::act_t head;

  assign head            = (cnt_r > 3'd1) ? slot_r[0] : sapc_pkg::ACT_IDLE_ENTRY;
  assign out_valid       = (cnt_r != 3'd0);
  assign out_action      = head.action;
  assign out_tx_type     = head.tx_type;
  assign out_tx_dest     = head.tx_dest;
  assign out_tx_active   = head.tx_active;
  assign out_alarm_state = st_state_r;
  assign out_peer        = st_peer_r;
  assign out_delivered   = st_deliv_r;
  assign out_last        = (cnt_r == 3'd1);

endmodule

`default_nettype wire
